// File: src/ubx_frm_pkg.sv
// Shared types and constants for the UBX fixed-frame receiver.
// No dependencies; used by ubx_frm_parser and ubx_fixed_frame_receiver_core.
`default_nettype none

package ubx_frm_pkg;

  // Sync pattern
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // Frame positions of the header steps
  localparam logic [6:0] POS_HUNT     = 7'd0;
  localparam logic [6:0] POS_SYNC2    = 7'd1;
  localparam logic [6:0] POS_CLASS    = 7'd2;
  localparam logic [6:0] POS_ID       = 7'd3;
  localparam logic [6:0] POS_LEN_LO   = 7'd4;
  localparam logic [6:0] POS_LEN_HI   = 7'd5;
  localparam logic [6:0] POS_PAYLOAD  = 7'd6;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CLASS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ID    = 8'd1;

  // Reset values of the configuration registers
  localparam logic [7:0] RST_CLASS = 8'h01;
  localparam logic [7:0] RST_ID    = 8'h07;

  // One result from the parser
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic [6:0] offset;
    logic       frame_end;
    logic       ck_ok;
  } ubx_res_t;

endpackage

`default_nettype wire

// File: src/ubx_fixed_frame_receiver_core.sv
// Top level of the UBX fixed-frame receiver: input register, parser, result register,
// configuration registers. Depends on ubx_frm_pkg and ubx_frm_parser.
//
//   channel | dir | tdata (low bit up)           | tuser       | tlast
//   in_     | in  | rx_byte[7:0]                 | -           | -
//   out_    | out | out_byte[7:0], byte_offset[14:8], 0 | checksum_ok | frame_end
//   cfg_    | in  | cfg_index: 0 class, 1 id; cfg_data[7:0]
//
// An accepted byte is loaded into the input register and then into the result
// register, from which its beat is offered; one byte is accepted per cycle while
// the result is not stalled. Header and checksum-A bytes give no beat.
// Synchronous active-low reset clears the frame position, sums and valid flags and
// restores class 0x01, id 0x07. A stalled result holds the pipeline; the input
// register still takes one byte while the result waits.
`default_nettype none

module ubx_fixed_frame_receiver_core #(
  parameter int unsigned PAYLOAD_LEN = 92
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input stream
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  input  wire logic [7:0]                       in_tdata,   // [7:0] rx_byte
  // result stream
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  output      logic [15:0]                      out_tdata,  // [7:0] out_byte, [14:8] byte_offset
  output      logic                             out_tlast,  // frame_end
  output      logic                             out_tuser,  // checksum_ok
  // configuration writes
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [ubx_frm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                       cfg_data
);
  import ubx_frm_pkg::*;

  logic       s1_vld_r;
  logic [7:0] s1_byte_r;
  logic       out_vld_r;
  logic [7:0] out_byte_r;
  logic [6:0] out_off_r;
  logic       out_end_r;
  logic       out_ok_r;
  logic [7:0] exp_class_r;
  logic [7:0] exp_id_r;
  logic       adv;
  ubx_res_t   res;

  // Pipeline moves when the result register is free or being drained
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || adv;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
  end

  ubx_frm_parser #(
    .PAYLOAD_LEN(PAYLOAD_LEN)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_vld_r && adv),
    .rx_byte   (s1_byte_r),
    .exp_class (exp_class_r),
    .exp_id    (exp_id_r),
    .res       (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= s1_vld_r && res.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_byte_r <= res.data;
      out_off_r  <= res.offset;
      out_end_r  <= res.frame_end;
      out_ok_r   <= res.ck_ok;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_off_r, out_byte_r};
  assign out_tlast  = out_end_r;
  assign out_tuser  = out_ok_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_class_r <= RST_CLASS;
      exp_id_r    <= RST_ID;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IDX_CLASS: exp_class_r <= cfg_data;
        CFG_IDX_ID:    exp_id_r    <= cfg_data;
        default:       ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: src/ubx_frm_parser.sv
// Frame position tracker and Fletcher-8 checksum for the UBX receiver.
// Depends on ubx_frm_pkg.
`default_nettype none

module ubx_frm_parser #(
  parameter int unsigned PAYLOAD_LEN = 92
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire logic [7:0]            rx_byte,
  input  wire logic [7:0]            exp_class,
  input  wire logic [7:0]            exp_id,
  output ubx_frm_pkg::ubx_res_t      res
);
  import ubx_frm_pkg::*;

  localparam logic [6:0] POS_CK_A = 7'(32'(POS_PAYLOAD) + PAYLOAD_LEN);
  localparam logic [6:0] POS_CK_B = 7'(32'(POS_PAYLOAD) + PAYLOAD_LEN + 1);
  localparam logic [7:0] LEN_LO   = 8'(PAYLOAD_LEN & 32'hFF);
  localparam logic [7:0] LEN_HI   = 8'((PAYLOAD_LEN >> 8) & 32'hFF);

  logic [6:0] pos_r, pos_nxt;
  logic [7:0] sum_a_r, sum_a_nxt;
  logic [7:0] sum_b_r, sum_b_nxt;
  logic [7:0] ck_a_r, ck_a_nxt;
  logic [6:0] pos_eff;
  logic [7:0] acc_a, acc_b;

  // Running sums with this byte added
  assign acc_a = sum_a_r + rx_byte;
  assign acc_b = sum_b_r + acc_a;

  // Position step, sum update and result
  always_comb begin
    pos_eff   = (pos_r > POS_CK_B) ? POS_HUNT : pos_r;
    pos_nxt   = POS_HUNT;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    ck_a_nxt  = ck_a_r;
    res       = '0;
    case (pos_eff)
      POS_HUNT: begin
        if (rx_byte == SYNC_FIRST) pos_nxt = POS_SYNC2;
      end
      POS_SYNC2: begin
        if (rx_byte == SYNC_SECOND) pos_nxt = POS_CLASS;
      end
      POS_CLASS: begin
        if (rx_byte == exp_class) begin
          // sums restart from zero with the class byte
          sum_a_nxt = rx_byte;
          sum_b_nxt = rx_byte;
          pos_nxt   = POS_ID;
        end
      end
      POS_ID: begin
        if (rx_byte == exp_id) begin
          sum_a_nxt = acc_a;
          sum_b_nxt = acc_b;
          pos_nxt   = POS_LEN_LO;
        end
      end
      POS_LEN_LO: begin
        if (rx_byte == LEN_LO) begin
          sum_a_nxt = acc_a;
          sum_b_nxt = acc_b;
          pos_nxt   = POS_LEN_HI;
        end
      end
      POS_LEN_HI: begin
        if (rx_byte == LEN_HI) begin
          sum_a_nxt = acc_a;
          sum_b_nxt = acc_b;
          pos_nxt   = POS_PAYLOAD;
        end
      end
      default: begin
        if (pos_eff < POS_CK_A) begin
          // payload beat
          sum_a_nxt  = acc_a;
          sum_b_nxt  = acc_b;
          res.vld    = 1'b1;
          res.data   = rx_byte;
          res.offset = pos_eff - POS_PAYLOAD;
          pos_nxt    = pos_eff + 7'd1;
        end else if (pos_eff == POS_CK_A) begin
          ck_a_nxt = rx_byte;
          pos_nxt  = POS_CK_B;
        end else begin
          // second checksum byte closes the frame
          res.vld       = 1'b1;
          res.frame_end = 1'b1;
          res.ck_ok     = (ck_a_r == sum_a_r) && (rx_byte == sum_b_r);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_HUNT;
      sum_a_r <= '0;
      sum_b_r <= '0;
      ck_a_r  <= '0;
    end else if (step) begin
      pos_r   <= pos_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      ck_a_r  <= ck_a_nxt;
    end
  end

endmodule

`default_nettype wire
